### design/tbhv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbhv_pkg: shared types and constants of the take-back-half velocity control
// Command format between front and back, register indexes and limits.
// ----------------------------------------------------------------------------
package tbhv_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_TARGET    = 2'd0;
  localparam logic [1:0] REG_GAIN      = 2'd1;
  localparam logic [1:0] REG_OPEN_LOOP = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // error sign codes
  typedef logic [1:0] sign_t;
  localparam sign_t SIGN_ZERO = 2'b00;
  localparam sign_t SIGN_POS  = 2'b01;
  localparam sign_t SIGN_NEG  = 2'b11;

  // accumulator clamp, +/-127.0 in Q8.8
  localparam logic signed [15:0] ACC_LIMIT     = 16'sd32512;
  localparam logic signed [15:0] ACC_LIMIT_NEG = -16'sd32512;

  // blend weights, 154/256 and 102/256
  localparam logic signed [25:0] W_SELF = 26'sd154;
  localparam logic signed [25:0] W_BASE = 26'sd102;

  // one classified tick, front to back
  typedef struct packed {
    logic signed [16:0] err;
    logic               crossed;
    logic               first;
  } tbhv_cmd_t;

endpackage
`default_nettype wire

### design/tbhv_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbhv_queue: short command queue between front and back
// Register-based first-in first-out buffer of classified ticks.
// ----------------------------------------------------------------------------
module tbhv_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr,
  input  wire tbhv_pkg::tbhv_cmd_t wr_data,
  output logic                    full,
  input  wire logic               rd,
  output tbhv_pkg::tbhv_cmd_t     rd_data,
  output logic                    empty
);
  import tbhv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tbhv_cmd_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd && !empty) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr && !full, rd && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/tbhv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbhv_front: configuration registers and tick classification
// Forms the velocity error, its sign and the crossing flags per tick.
// ----------------------------------------------------------------------------
module tbhv_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [tbhv_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [tbhv_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                push,
  input  wire logic signed [15:0]                  measured_velocity,
  input  wire logic                                q_full,
  output logic                                     q_wr,
  output tbhv_pkg::tbhv_cmd_t                      q_data,
  output logic [15:0]                              loop_gain,
  output logic signed [7:0]                        open_loop_drive
);
  import tbhv_pkg::*;

  logic signed [15:0] target_velocity;
  sign_t              prev_sign;
  logic               first_pending;
  logic signed [16:0] err;
  sign_t              err_sign;

  // error and its sign
  always_comb begin
    err = 17'(target_velocity) - 17'(measured_velocity);
    if (err == '0) begin
      err_sign = SIGN_ZERO;
    end else if (err[16]) begin
      err_sign = SIGN_NEG;
    end else begin
      err_sign = SIGN_POS;
    end
  end

  assign q_wr           = push && !q_full;
  assign q_data.err     = err;
  assign q_data.crossed = (err_sign != prev_sign);
  assign q_data.first   = first_pending;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_velocity <= '0;
      loop_gain       <= '0;
      open_loop_drive <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TARGET:    target_velocity <= signed'(cfg_data);
        REG_GAIN:      loop_gain       <= cfg_data;
        REG_OPEN_LOOP: open_loop_drive <= signed'(cfg_data[7:0]);
        default:       ;
      endcase
    end
  end

  // sign history and first-crossing flag
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sign     <= SIGN_ZERO;
      first_pending <= 1'b1;
    end else begin
      if (q_wr) begin
        prev_sign <= err_sign;
        if (q_data.crossed) begin
          first_pending <= 1'b0;
        end
      end
      if (cfg_write && cfg_index == REG_TARGET) begin
        first_pending <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### design/tbhv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbhv_back: integration, clamp and take-back-half update
// Serial error-times-gain multiply, accumulator update and result register.
// ----------------------------------------------------------------------------
module tbhv_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tbhv_pkg::tbhv_cmd_t   q_data,
  input  wire logic                  q_empty,
  output logic                       q_rd,
  input  wire logic [15:0]           loop_gain,
  input  wire logic signed [7:0]     open_loop_drive,
  output logic                       empty,
  input  wire logic                  pop,
  output logic signed [7:0]          drive,
  output logic signed [16:0]         velocity_error,
  output logic                       crossed
);
  import tbhv_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t             state;
  tbhv_cmd_t          cmd;
  logic signed [32:0] mcand;
  logic [15:0]        mplier;
  logic signed [32:0] prod;
  logic [2:0]         step;
  logic signed [15:0] acc;
  logic signed [15:0] base;
  logic signed [15:0] sum_clamp;
  logic               out_valid;
  logic signed [15:0] out_acc;

  logic signed [32:0] partial;
  logic signed [28:0] prod_q88;
  logic signed [29:0] sum_wide;
  logic signed [15:0] open_acc;
  logic signed [25:0] blend_sum;
  logic signed [15:0] acc_final;
  logic               out_free;

  assign out_free = !out_valid || pop;
  assign q_rd     = (state == ST_IDLE) && !q_empty;
  assign empty    = !out_valid;

  // two multiplier bits per cycle
  always_comb begin
    case (mplier[1:0])
      2'd0:    partial = '0;
      2'd1:    partial = mcand;
      2'd2:    partial = mcand <<< 1;
      2'd3:    partial = mcand + (mcand <<< 1);
      default: partial = '0;
    endcase
  end

  // integration and clamp
  always_comb begin
    prod_q88 = 29'(prod >>> 4);
    sum_wide = 30'(prod_q88) + 30'(acc);
    if (sum_wide > 30'(ACC_LIMIT)) begin
      sum_wide = 30'(ACC_LIMIT);
    end else if (sum_wide < 30'(ACC_LIMIT_NEG)) begin
      sum_wide = 30'(ACC_LIMIT_NEG);
    end
  end

  // crossing update
  always_comb begin
    open_acc = {open_loop_drive, 8'h00};
    if (open_acc < ACC_LIMIT_NEG) begin
      open_acc = ACC_LIMIT_NEG;
    end
    blend_sum = 26'(sum_clamp) * W_SELF + 26'(base) * W_BASE;
    if (!cmd.crossed) begin
      acc_final = sum_clamp;
    end else if (cmd.first) begin
      acc_final = open_acc;
    end else begin
      acc_final = blend_sum[23:8];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      acc   <= '0;
      base  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (step == 3'd7) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (out_free) begin
            acc <= acc_final;
            if (cmd.crossed) begin
              base <= acc_final;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd    <= q_data;
        mcand  <= 33'(q_data.err);
        mplier <= loop_gain;
        prod   <= '0;
        step   <= '0;
      end
      ST_MUL: begin
        prod   <= prod + partial;
        mcand  <= mcand <<< 2;
        mplier <= mplier >> 2;
        step   <= step + 1'b1;
      end
      ST_SUM: begin
        sum_clamp <= 16'(sum_wide);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_UPD && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPD && out_free) begin
      out_acc        <= acc_final;
      velocity_error <= cmd.err;
      crossed        <= cmd.crossed;
    end
  end

  // drive truncated toward zero
  assign drive = out_acc[15:8] + 8'((out_acc[15] && out_acc[7:0] != 8'h00) ? 1 : 0);

  // accumulator never leaves the clamp range
  assert property (@(posedge clk) disable iff (rst)
    acc <= ACC_LIMIT && acc >= ACC_LIMIT_NEG)
    else $error("accumulator outside clamp range");

  // a crossing leaves base equal to the accumulator
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && out_free && cmd.crossed) |=> (base == acc))
    else $error("crossing base not saved");

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> ($stable(out_acc) && $stable(velocity_error)))
    else $error("result overwritten before transfer");

endmodule
`default_nettype wire

### design/take_back_half_velocity_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// take_back_half_velocity_control: take-back-half velocity controller
// Integrating drive controller with take-back-half update at error crossings.
// ----------------------------------------------------------------------------
// Each measured velocity pushed in yields one result: the drive command, the
// velocity error and a crossing flag. The front classifies a tick in the cycle
// it is pushed and queues it; the back then takes each tick through its steps:
// load, the error-times-gain multiply at two gain bits per cycle, integrate and
// clamp, then update and register the result, which waits while an earlier
// result is not yet popped. A new tick is taken only from the idle state.
// Registers are written through cfg_write, cfg_index and cfg_data; the user
// must write them only while no tick is in flight, which the block does not
// enforce; writing the target re-arms the first crossing.
module take_back_half_velocity_control #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [tbhv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [tbhv_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic signed [15:0]                measured_velocity,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic signed [7:0]                      drive,
  output logic signed [16:0]                     velocity_error,
  output logic                                   crossed
);
  import tbhv_pkg::*;

  tbhv_cmd_t          q_in;
  tbhv_cmd_t          q_out;
  logic               q_wr;
  logic               q_rd;
  logic               q_empty;
  logic [15:0]        loop_gain;
  logic signed [7:0]  open_loop_drive;

  // tick classification and registers
  tbhv_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .push              (push),
    .measured_velocity (measured_velocity),
    .q_full            (full),
    .q_wr              (q_wr),
    .q_data            (q_in),
    .loop_gain         (loop_gain),
    .open_loop_drive   (open_loop_drive)
  );

  // decoupling queue
  tbhv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_in),
    .full    (full),
    .rd      (q_rd),
    .rd_data (q_out),
    .empty   (q_empty)
  );

  // integration and crossing update
  tbhv_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_data          (q_out),
    .q_empty         (q_empty),
    .q_rd            (q_rd),
    .loop_gain       (loop_gain),
    .open_loop_drive (open_loop_drive),
    .empty           (empty),
    .pop             (pop),
    .drive           (drive),
    .velocity_error  (velocity_error),
    .crossed         (crossed)
  );

endmodule
`default_nettype wire
